// ===== src/epsm_pkg.sv =====
`timescale 1ns / 1ps

package epsm_pkg;

  // fixed field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OVF_W  = 16;
  localparam int unsigned EDGE_W = 8;
  localparam int unsigned ADDR_W = 3;

  // register map, word index taken from paddr[2]
  localparam logic REG_NUMERATOR = 1'b0;
  localparam logic REG_EDGES     = 1'b1;

  localparam logic [DATA_W-1:0] NUMERATOR_RST = 32'd60000000;
  localparam logic [EDGE_W-1:0] EDGES_RST     = 8'd5;
  localparam logic [EDGE_W-1:0] EDGES_MIN     = 8'd2;

  // divider state
  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_state_t;

  // divider status seen by the top level
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== src/epsm_div.sv =====
`timescale 1ns / 1ps

module epsm_div
  import epsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  input  logic              take,
  output div_stat_t         stat,
  output logic [DATA_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(DATA_W);

  div_state_t        state;
  div_state_t        state_next;
  logic [CNT_W-1:0]  step;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W:0]   trial;
  logic [DATA_W+1:0] diff;
  logic              fits;

  // one quotient bit per cycle: shift in a dividend bit, try the subtract
  assign trial = {rem, quo[DATA_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs};
  assign fits  = ~diff[DATA_W+1];

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: begin
        if (start) state_next = DIV_RUN;
      end
      DIV_RUN: begin
        if (step == CNT_W'(DATA_W - 1)) state_next = DIV_DONE;
      end
      DIV_DONE: begin
        if (take) state_next = DIV_IDLE;
      end
      default: state_next = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    if (state == DIV_IDLE && start) begin
      rem  <= '0;
      quo  <= dividend;
      dvs  <= divisor;
      step <= '0;
    end else if (state == DIV_RUN) begin
      rem  <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo  <= {quo[DATA_W-2:0], fits};
      step <= step + CNT_W'(1);
    end
  end

  assign stat.busy = (state != DIV_IDLE);
  assign stat.done = (state == DIV_DONE);
  assign quotient  = quo;

endmodule

// ===== src/encoder_period_speed_meter.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  tick, encoder_edge
// out       output     out_valid/out_stall  speed, period, zero_period
// cfg       input      apb write/read       numerator @0x0, edges_per_window @0x4
//
// an item that does not close a window is taken every cycle while in_stall is low
// an item that closes a window starts a radix-2 divide of 32 steps in epsm_div;
// in_stall stays high through the divide and the done state, longer while
// the result waits on a stalled output register
// rst is synchronous and clears counters, config registers, out_valid and the divider sequencer

module encoder_period_speed_meter
  import epsm_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  // input items
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              tick,
  input  logic              encoder_edge,
  // result items
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] speed,
  output logic [DATA_W-1:0] period,
  output logic              zero_period,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int unsigned PER_W = OVF_W + TIMER_BITS;
  localparam int unsigned EXT_W = (PER_W > DATA_W) ? PER_W : DATA_W + 1;

  logic [DATA_W-1:0]     numerator;
  logic [EDGE_W-1:0]     edges_per_window;
  logic [TIMER_BITS-1:0] tick_count;
  logic [TIMER_BITS-1:0] tick_count_next;
  logic [OVF_W-1:0]      overflow_count;
  logic [OVF_W-1:0]      overflow_count_next;
  logic [EDGE_W-1:0]     edge_count;
  logic [EDGE_W-1:0]     edge_inc;
  logic [EDGE_W-1:0]     limit;
  logic [EXT_W-1:0]      period_ext;
  logic [DATA_W-1:0]     period_sat;
  logic [DATA_W-1:0]     cap_period;
  logic                  cap_zero;
  logic                  in_take;
  logic                  capture;
  logic                  out_load;
  div_stat_t             div_stat;
  logic [DATA_W-1:0]     quotient;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      numerator        <= NUMERATOR_RST;
      edges_per_window <= EDGES_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_NUMERATOR: numerator        <= pwdata;
        REG_EDGES:     edges_per_window <= pwdata[EDGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NUMERATOR: prdata = numerator;
      REG_EDGES:     prdata = DATA_W'(edges_per_window);
      default:       prdata = '0;
    endcase
  end

  // timer advance on a tick, overflow count saturates
  always_comb begin
    tick_count_next     = tick_count;
    overflow_count_next = overflow_count;
    if (tick) begin
      tick_count_next = tick_count + TIMER_BITS'(1);
      if (tick_count == '1 && overflow_count != '1) begin
        overflow_count_next = overflow_count + OVF_W'(1);
      end
    end
  end

  // edge bookkeeping
  assign edge_inc = edge_count + EDGE_W'(1);
  assign limit    = (edges_per_window < EDGES_MIN) ? EDGES_MIN : edges_per_window;
  assign in_take  = in_valid && !in_stall;
  assign capture  = in_take && encoder_edge && edge_inc != EDGE_W'(1) && edge_inc >= limit;

  // period from the counts after this beat's tick, clipped to 32 bits
  assign period_ext = EXT_W'({overflow_count_next, tick_count_next});
  assign period_sat = (|period_ext[EXT_W-1:DATA_W]) ? '1 : period_ext[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      overflow_count <= '0;
      edge_count     <= '0;
    end else if (in_take) begin
      tick_count     <= tick_count_next;
      overflow_count <= overflow_count_next;
      if (encoder_edge) begin
        if (edge_inc == EDGE_W'(1)) begin
          tick_count     <= '0;
          overflow_count <= '0;
          edge_count     <= edge_inc;
        end else if (capture) begin
          edge_count <= '0;
        end else begin
          edge_count <= edge_inc;
        end
      end
    end
  end

  // captured period waits beside the divider
  always_ff @(posedge clk) begin
    if (capture) begin
      cap_period <= period_sat;
      cap_zero   <= (period_sat == '0);
    end
  end

  // divide by zero yields all ones, matching the saturated speed
  epsm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (capture),
    .dividend (numerator),
    .divisor  (period_sat),
    .take     (out_load),
    .stat     (div_stat),
    .quotient (quotient)
  );

  assign in_stall = div_stat.busy;

  // output register
  assign out_load = div_stat.done && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      speed       <= quotient;
      period      <= cap_period;
      zero_period <= cap_zero;
    end
  end

endmodule

// ===== src/epsm_chk.sv =====
`timescale 1ns / 1ps

module epsm_chk
  import epsm_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DATA_W-1:0] speed,
  input logic [DATA_W-1:0] period,
  input logic              zero_period
);

  // a result beat that is held back stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // zero flag agrees with the period
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (zero_period == (period == '0)))
    else $error("zero_period does not match period");

  // zero period gives the saturated speed
  a_zero_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_period |-> speed == '1)
    else $error("zero period without saturated speed");

  // a new result only follows a divide that held the input
  a_new_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a divide in flight");

endmodule

bind encoder_period_speed_meter epsm_chk u_epsm_chk (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .speed       (speed),
  .period      (period),
  .zero_period (zero_period)
);

// ===== sim/encoder_period_speed_meter_tb.sv =====
`timescale 1ns / 1ps

module encoder_period_speed_meter_tb
  import epsm_pkg::*;
();

  localparam int unsigned TB_TIMER_BITS = 16;
  localparam int unsigned IDLE_PCT      = 12;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RAND_BEATS    = 850;
  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam logic [EDGE_W-1:0] FLOOR_EDGES = 8'd2;

  // one speed reading as the block reports it
  typedef struct packed {
    logic [DATA_W-1:0] speed;
    logic [DATA_W-1:0] period;
    logic              zero;
  } speed_rec_t;

  typedef enum logic {
    ROW_BEAT,
    ROW_WRITE
  } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic              reg_sel;
    logic [DATA_W-1:0] wdata;
    logic              tick_v;
    logic              edge_v;
    int unsigned       reps;
    bit                typed;
    speed_rec_t        typed_rec;
  } stim_row_t;

  logic              clk;
  logic              rst          = 1'b1;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic              tick         = 1'b0;
  logic              encoder_edge = 1'b0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic [DATA_W-1:0] speed;
  logic [DATA_W-1:0] period;
  logic              zero_period;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [ADDR_W-1:0] paddr        = '0;
  logic [DATA_W-1:0] pwdata       = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // tachometer copy: timer, wraps, edges of the window and the two registers
  logic [TB_TIMER_BITS-1:0] mtr_timer     = '0;
  logic [OVF_W-1:0]         mtr_wraps     = '0;
  logic [EDGE_W-1:0]        mtr_edges     = '0;
  logic [DATA_W-1:0]        mtr_numerator = 32'd60000000;
  logic [EDGE_W-1:0]        mtr_target    = 8'd5;

  speed_rec_t  speed_q[$];
  stim_row_t   dir_table[$];
  bit          no_idle       = 1'b0;
  bit          beat_typed    = 1'b0;
  speed_rec_t  beat_rec      = '0;
  int unsigned mismatches    = 0;
  int unsigned cycle_cnt     = 0;
  bit          fired;
  speed_rec_t  calc_rec;
  speed_rec_t  want_rec;

  encoder_period_speed_meter #(
    .TIMER_BITS(TB_TIMER_BITS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .tick        (tick),
    .encoder_edge(encoder_edge),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .speed       (speed),
    .period      (period),
    .zero_period (zero_period),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // tick first, then edge; a capture closes the window and yields one reading
  function automatic void tach_step(input logic t, input logic e, output bit got,
                                    output speed_rec_t rec);
    logic [EDGE_W-1:0] target;
    logic [63:0]       span;
    got = 1'b0;
    rec = '0;
    if (t) begin
      if (&mtr_timer) begin
        mtr_timer = '0;
        if (mtr_wraps != '1) mtr_wraps = mtr_wraps + OVF_W'(1);
      end else begin
        mtr_timer = mtr_timer + TB_TIMER_BITS'(1);
      end
    end
    if (e) begin
      mtr_edges = mtr_edges + EDGE_W'(1);
      target = (mtr_target < FLOOR_EDGES) ? FLOOR_EDGES : mtr_target;
      if (mtr_edges == 8'd1) begin
        mtr_timer = '0;
        mtr_wraps = '0;
      end else if (mtr_edges >= target) begin
        mtr_edges = '0;
        span = (64'(mtr_wraps) << TB_TIMER_BITS) + 64'(mtr_timer);
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        got = 1'b1;
        rec.period = span[DATA_W-1:0];
        if (span == 64'd0) begin
          rec.speed = '1;
          rec.zero  = 1'b1;
        end else begin
          rec.speed = DATA_W'(64'(mtr_numerator) / span);
          rec.zero  = 1'b0;
        end
      end
    end
  endfunction

  function automatic void check_field(input string what, input logic [DATA_W-1:0] want,
                                      input logic [DATA_W-1:0] got);
    if (got !== want) begin
      if (mismatches < MAX_REPORTS)
        $display("mismatch on %s: expected %h, got %h", what, want, got);
      mismatches++;
    end
  endfunction

  // output beats against the oldest reading, then input beats into the copy
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (speed_q.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("unexpected reading: speed %h period %h zero %b",
                     speed, period, zero_period);
          mismatches++;
        end else begin
          want_rec = speed_q.pop_front();
          check_field("speed", want_rec.speed, speed);
          check_field("period", want_rec.period, period);
          check_field("zero_period", DATA_W'(want_rec.zero), DATA_W'(zero_period));
        end
      end
      if (in_valid && !in_stall) begin
        tach_step(tick, encoder_edge, fired, calc_rec);
        if (fired) speed_q.push_back(beat_typed ? beat_rec : calc_rec);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
  end

  // one input beat, entered and left at a falling edge
  task automatic send_beat(input logic t, input logic e, input bit typed,
                           input speed_rec_t rec);
    while (!no_idle && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    tick         <= t;
    encoder_edge <= e;
    beat_typed   = typed;
    beat_rec     = rec;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // wait until no reading is owed and the divider has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (speed_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // apb setup and access phases
  task automatic write_reg(input logic sel, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({sel, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == REG_NUMERATOR) mtr_numerator = value;
    else mtr_target = value[EDGE_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_numerator();
    logic [DATA_W-1:0] val;
    case ($urandom_range(5))
      0: val = 32'd1;
      1: val = 32'hFFFF_FFFF;
      2: val = DATA_W'($urandom_range(1000, 1));
      3: val = 32'd60000000;
      default: val = $urandom();
    endcase
    return (val == '0) ? 32'd1 : val;
  endfunction

  function automatic logic [DATA_W-1:0] pick_edges();
    case ($urandom_range(19))
      0: return 32'd255;
      1: return DATA_W'($urandom_range(1, 0));
      2, 3: return DATA_W'($urandom_range(40, 9));
      default: return DATA_W'($urandom_range(8, 2));
    endcase
  endfunction

  initial begin
    int unsigned rand_beats;
    int unsigned burst;
    int unsigned tick_pct;
    int unsigned edge_pct;
    bit          noise;
    logic        t;
    logic        e;

    dir_table = '{
      // a full default window of encoder edges with no tick after reset: zero period
      '{ROW_BEAT, 1'b0, 32'd0, 1'b0, 1'b1, 5, 1'b1, '{32'hFFFF_FFFF, 32'd0, 1'b1}},
      // tick and edge in one beat: the opening edge clears after the tick
      '{ROW_BEAT, 1'b0, 32'd0, 1'b1, 1'b1, 1, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b1, 1'b0, 10, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b1, 1'b1, 4, 1'b0, '0},
      // timer runs between windows
      '{ROW_BEAT, 1'b0, 32'd0, 1'b1, 1'b0, 20, 1'b0, '0},
      // largest numerator over a one-tick period
      '{ROW_WRITE, REG_NUMERATOR, 32'hFFFF_FFFF, 1'b0, 1'b0, 0, 1'b0, '0},
      '{ROW_WRITE, REG_EDGES, 32'd2, 1'b0, 1'b0, 0, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b0, 1'b1, 1, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b1, 1'b0, 1, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b0, 1'b1, 1, 1'b1, '{32'hFFFF_FFFF, 32'd1, 1'b0}},
      // smallest numerator
      '{ROW_WRITE, REG_NUMERATOR, 32'd1, 1'b0, 1'b0, 0, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b0, 1'b1, 1, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b1, 1'b0, 3, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b0, 1'b1, 1, 1'b1, '{32'd0, 32'd3, 1'b0}},
      // widest window
      '{ROW_WRITE, REG_EDGES, 32'd255, 1'b0, 1'b0, 0, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b0, 1'b1, 1, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b1, 1'b1, 254, 1'b0, '0},
      // edge settings below two act as two
      '{ROW_WRITE, REG_NUMERATOR, 32'd1000, 1'b0, 1'b0, 0, 1'b0, '0},
      '{ROW_WRITE, REG_EDGES, 32'd0, 1'b0, 1'b0, 0, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b0, 1'b1, 1, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b1, 1'b0, 5, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b0, 1'b1, 1, 1'b1, '{32'd200, 32'd5, 1'b0}},
      '{ROW_WRITE, REG_EDGES, 32'd1, 1'b0, 1'b0, 0, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b1, 1'b1, 1, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b1, 1'b0, 7, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b1, 1'b1, 1, 1'b1, '{32'd125, 32'd8, 1'b0}},
      // setting lowered inside an open window
      '{ROW_WRITE, REG_EDGES, 32'd10, 1'b0, 1'b0, 0, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b1, 1'b1, 4, 1'b0, '0},
      '{ROW_WRITE, REG_EDGES, 32'd3, 1'b0, 1'b0, 0, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b1, 1'b1, 1, 1'b0, '0},
      // long window at the default numerator
      '{ROW_WRITE, REG_NUMERATOR, 32'd60000000, 1'b0, 1'b0, 0, 1'b0, '0},
      '{ROW_WRITE, REG_EDGES, 32'd2, 1'b0, 1'b0, 0, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b0, 1'b1, 1, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b1, 1'b0, 100, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b0, 1'b1, 1, 1'b0, '0},
      // ticks between windows are cleared by the opening edge
      '{ROW_BEAT, 1'b0, 32'd0, 1'b1, 1'b0, 20, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b1, 1'b1, 1, 1'b0, '0},
      '{ROW_BEAT, 1'b0, 32'd0, 1'b0, 1'b1, 1, 1'b1, '{32'hFFFF_FFFF, 32'd0, 1'b1}}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_WRITE) begin
        settle();
        write_reg(dir_table[i].reg_sel, dir_table[i].wdata);
      end else begin
        repeat (dir_table[i].reps)
          send_beat(dir_table[i].tick_v, dir_table[i].edge_v, dir_table[i].typed,
                    dir_table[i].typed_rec);
      end
    end

    // random bursts, each under a fresh or carried-over setting
    rand_beats = 0;
    while (rand_beats < RAND_BEATS) begin
      settle();
      case ($urandom_range(3))
        1: write_reg(REG_NUMERATOR, pick_numerator());
        2: write_reg(REG_EDGES, pick_edges());
        3: begin
          write_reg(REG_NUMERATOR, pick_numerator());
          write_reg(REG_EDGES, pick_edges());
        end
        default: ;
      endcase
      burst = $urandom_range(120, 20);
      case ($urandom_range(4))
        0: tick_pct = 0;
        1: tick_pct = 10;
        2: tick_pct = 50;
        3: tick_pct = 90;
        default: tick_pct = 100;
      endcase
      case ($urandom_range(2))
        0: edge_pct = 50;
        1: edge_pct = 20;
        default: edge_pct = 5;
      endcase
      noise = ($urandom_range(99) < 20);
      repeat (burst) begin
        no_idle = (rand_beats >= 500 && rand_beats < 800);
        if (noise) begin
          t = 1'($urandom_range(1));
          e = 1'($urandom_range(1));
        end else begin
          t = ($urandom_range(99) < tick_pct);
          e = ($urandom_range(99) < edge_pct);
        end
        send_beat(t, e, 1'b0, '0);
        rand_beats++;
      end
    end
    no_idle = 1'b0;

    // drain and let the divider finish
    in_valid <= 1'b0;
    while (speed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && speed_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
